// ===== design/tcc_pkg.sv =====
package tcc_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int BYTE_W = 8;

    localparam int TAB_STOP = 8;

    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_FF  = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;

    localparam logic [BYTE_W-1:0] FILL_CHAR  = 8'h20;
    localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h07;

    localparam logic MODE_PUT = 1'b0;
    localparam logic MODE_SET = 1'b1;

    // APB register map: 32-bit words; only word 0 holds a register
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ATTRIBUTE = 1'b0;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_SCROLL = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef struct packed {
        t_action           action;
        logic [COL_W-1:0]  cell_col;
        logic [ROW_W-1:0]  cell_row;
        logic [BYTE_W-1:0] cell_char;
        logic [BYTE_W-1:0] cell_attr;
        logic [COL_W-1:0]  cursor_col_now;
        logic [ROW_W-1:0]  cursor_row_now;
        logic              last_result;
    } t_result;

    typedef struct packed {
        logic    push;
        logic    two;
        t_result first;
        t_result second;
    } t_push;

endpackage

// ===== design/tcc_if.sv =====
interface tcc_in_if;
    import tcc_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] col_request;
    logic [BYTE_W-1:0] row_request;

    modport source (output valid, mode, char_code, col_request, row_request, input ready);
    modport sink   (input valid, mode, char_code, col_request, row_request, output ready);
endinterface

interface tcc_out_if;
    import tcc_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [COL_W-1:0]  cell_col;
    logic [ROW_W-1:0]  cell_row;
    logic [BYTE_W-1:0] cell_char;
    logic [BYTE_W-1:0] cell_attr;
    logic [COL_W-1:0]  cursor_col_now;
    logic [ROW_W-1:0]  cursor_row_now;
    logic              last_result;

    modport source (output valid, action, cell_col, cell_row, cell_char, cell_attr,
                    cursor_col_now, cursor_row_now, last_result, input ready);
    modport sink   (input valid, action, cell_col, cell_row, cell_char, cell_attr,
                    cursor_col_now, cursor_row_now, last_result, output ready);
endinterface

// ===== design/tcc_cfg.sv =====
module tcc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tcc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tcc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [tcc_pkg::BYTE_W-1:0]        o_attr
);
    import tcc_pkg::*;

    logic [BYTE_W-1:0] r_attr;
    logic              hit;

    // word index sits above the byte lanes
    assign hit    = (paddr[APB_ADDR_W-1] == REG_ATTRIBUTE);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (psel && penable && pwrite && pready && hit) begin
            r_attr <= pwdata[BYTE_W-1:0];
        end
    end

    assign prdata = hit ? {{(APB_DATA_W-BYTE_W){1'b0}}, r_attr} : '0;
    assign o_attr = r_attr;
endmodule

// ===== design/tcc_cursor.sv =====
module tcc_cursor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tcc_in_if.sink                     i_in,
    input  logic [tcc_pkg::BYTE_W-1:0] i_attr,
    input  logic                       i_room,
    output tcc_pkg::t_push             o_push
);
    import tcc_pkg::*;

    logic              r_in_vld;
    logic              r_mode;
    logic [BYTE_W-1:0] r_char;
    logic [BYTE_W-1:0] r_creq;
    logic [BYTE_W-1:0] r_rreq;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    logic              advance;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [ROW_W:0]    row_inc;
    logic              nl_scroll;
    logic [ROW_W-1:0]  nl_row;
    logic [COL_W:0]    col_inc;
    logic [COL_W:0]    tab_col;
    logic              scroll;
    logic              wrote;
    logic              clear;
    t_result           first;
    t_result           second;

    assign advance    = r_in_vld && i_room;
    assign i_in.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (advance) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_mode <= i_in.mode;
            r_char <= i_in.char_code;
            r_creq <= i_in.col_request;
            r_rreq <= i_in.row_request;
        end
    end

    // new line: column 0, next row unless already on the last one
    assign row_inc   = {1'b0, r_row} + (ROW_W+1)'(1);
    assign nl_scroll = (row_inc >= (ROW_W+1)'(ROWS));
    assign nl_row    = nl_scroll ? r_row : row_inc[ROW_W-1:0];
    assign col_inc   = {1'b0, r_col} + (COL_W+1)'(1);
    assign tab_col   = ({1'b0, r_col} + (COL_W+1)'(TAB_STOP)) & ~(COL_W+1)'(TAB_STOP-1);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        scroll = 1'b0;
        wrote  = 1'b0;
        clear  = 1'b0;
        if (r_mode == MODE_SET) begin
            n_col = (r_creq < BYTE_W'(COLUMNS)) ? r_creq[COL_W-1:0] : COL_W'(COLUMNS-1);
            n_row = (r_rreq < BYTE_W'(ROWS))    ? r_rreq[ROW_W-1:0] : ROW_W'(ROWS-1);
        end else begin
            unique case (r_char)
                CH_BS: begin
                    if (r_col != '0) begin
                        n_col = r_col - COL_W'(1);
                    end
                end
                CH_TAB: begin
                    if (tab_col >= (COL_W+1)'(COLUMNS)) begin
                        n_col  = '0;
                        n_row  = nl_row;
                        scroll = nl_scroll;
                    end else begin
                        n_col = tab_col[COL_W-1:0];
                    end
                end
                CH_LF: begin
                    n_col  = '0;
                    n_row  = nl_row;
                    scroll = nl_scroll;
                end
                CH_CR: begin
                    n_col = '0;
                end
                CH_FF: begin
                    n_col = '0;
                    n_row = '0;
                    clear = 1'b1;
                end
                default: begin
                    wrote = 1'b1;
                    if (col_inc >= (COL_W+1)'(COLUMNS)) begin
                        n_col  = '0;
                        n_row  = nl_row;
                        scroll = nl_scroll;
                    end else begin
                        n_col = col_inc[COL_W-1:0];
                    end
                end
            endcase
        end
    end

    always_comb begin
        first  = '0;
        second = '0;
        first.action         = ACT_NONE;
        first.cursor_col_now = n_col;
        first.cursor_row_now = n_row;
        first.last_result    = 1'b1;
        second.action         = ACT_SCROLL;
        second.cell_char      = FILL_CHAR;
        second.cell_attr      = i_attr;
        second.cursor_col_now = n_col;
        second.cursor_row_now = n_row;
        second.last_result    = 1'b1;
        if (wrote) begin
            first.action      = ACT_WRITE;
            first.cell_col    = r_col;
            first.cell_row    = r_row;
            first.cell_char   = r_char;
            first.cell_attr   = i_attr;
            first.last_result = !scroll;
        end else if (clear || scroll) begin
            first.action    = clear ? ACT_CLEAR : ACT_SCROLL;
            first.cell_char = FILL_CHAR;
            first.cell_attr = i_attr;
        end
    end

    assign o_push.push   = advance;
    assign o_push.two    = wrote && scroll;
    assign o_push.first  = first;
    assign o_push.second = second;
endmodule

// ===== design/tcc_result_fifo.sv =====
module tcc_result_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcc_pkg::t_push i_push,
    output logic           o_room,
    tcc_out_if.source      o_out
);
    import tcc_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic [FIFO_PTR_W-1:0] wr_next;
    logic                  pop;
    logic [FIFO_CNT_W-1:0] n_push;
    t_result               head;

    assign wr_next = r_wr + FIFO_PTR_W'(1);
    assign pop     = o_out.valid && o_out.ready;
    assign n_push  = !i_push.push ? '0 : (i_push.two ? FIFO_CNT_W'(2) : FIFO_CNT_W'(1));
    // keep space for the two beats a wrapping character may need
    assign o_room  = (r_cnt <= FIFO_CNT_W'(FIFO_DEPTH-2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + n_push[FIFO_PTR_W-1:0];
            r_cnt <= r_cnt + n_push - FIFO_CNT_W'(pop);
            if (pop) begin
                r_rd <= r_rd + FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.first;
            if (i_push.two) begin
                r_mem[wr_next] <= i_push.second;
            end
        end
    end

    assign head = r_mem[r_rd];

    assign o_out.valid          = (r_cnt != '0);
    assign o_out.action         = head.action;
    assign o_out.cell_col       = head.cell_col;
    assign o_out.cell_row       = head.cell_row;
    assign o_out.cell_char      = head.cell_char;
    assign o_out.cell_attr      = head.cell_attr;
    assign o_out.cursor_col_now = head.cursor_col_now;
    assign o_out.cursor_row_now = head.cursor_row_now;
    assign o_out.last_result    = head.last_result;
endmodule

// ===== design/text_console_cursor_control.sv =====
// Channel   Dir  Beat contents
// i_in      in   mode, char_code, col_request, row_request
// o_out     out  action, cell/cursor position, char, attr, last_result
// APB       in   attribute register at byte address 0
//
// One input beat is taken per cycle while the queue has room, via the input register.
// Any byte but BS, TAB, LF, CR and FF that wraps on the last row produces two beats,
// so the output side sets the rate at one result beat per cycle while o_out is ready.
// Reset (i_rst_n low at a clock edge) homes the cursor and sets attribute 0x07.
// A stalled o_out fills a four-entry result queue; i_in holds off only
// once fewer than two entries remain free.
module text_console_cursor_control (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tcc_in_if.sink                            i_in,
    tcc_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tcc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tcc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import tcc_pkg::*;

    logic [BYTE_W-1:0] attr;
    logic              room;
    t_push             push;

    // attribute register; the user must write it only while the block is idle, the block does not enforce it
    tcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_attr  (attr)
    );

    // input register, cursor state and the combinational decode
    tcc_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_attr  (attr),
        .i_room  (room),
        .o_push  (push)
    );

    // result queue decouples the two-beat case from the input side
    tcc_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );
endmodule

// ===== dv/text_console_cursor_control_tb.sv =====
module text_console_cursor_control_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcc_pkg::*;

    // Input beat as the sender drives it.
    typedef struct {
        logic              mode;
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] col;
        logic [BYTE_W-1:0] row;
    } t_beat;

    // Directed row: a beat plus, where obvious, the hand-written outcome of its lead result.
    typedef struct {
        t_beat   beat;
        bit      typed;
        t_action act;
        int      col_now;
        int      row_now;
    } t_directed_row;

    localparam int DIRECTED_N      = 25;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 213;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 40;

    localparam logic [APB_ADDR_W-1:0] ATTR_ADDR = {REG_ATTRIBUTE, 2'b00};

    // Hand-checked opening sequence, starting from the reset cursor at (0,0)
    // and the reset attribute. Ignored fields carry all-ones or odd bytes.
    t_directed_row directed_rows [DIRECTED_N] = '{
        '{'{MODE_PUT, 8'h41, 8'hFF, 8'hFF}, 1'b1, ACT_WRITE,  1,  0},  // plain cell
        '{'{MODE_PUT, CH_BS, 8'h00, 8'h00}, 1'b1, ACT_NONE,   0,  0},  // backspace
        '{'{MODE_PUT, CH_BS, 8'hFF, 8'h00}, 1'b1, ACT_NONE,   0,  0},  // backspace at column 0
        '{'{MODE_PUT, CH_TAB, 8'h00, 8'hFF}, 1'b1, ACT_NONE,  8,  0},
        '{'{MODE_PUT, CH_TAB, 8'h00, 8'h00}, 1'b1, ACT_NONE, 16,  0},
        '{'{MODE_PUT, CH_CR, 8'h00, 8'h00}, 1'b1, ACT_NONE,   0,  0},
        '{'{MODE_PUT, CH_LF, 8'h00, 8'h00}, 1'b1, ACT_NONE,   0,  1},
        '{'{MODE_PUT, CH_FF, 8'h00, 8'h00}, 1'b1, ACT_CLEAR,  0,  0},  // clear screen
        '{'{MODE_SET, CH_FF, 8'hFF, 8'hFF}, 1'b1, ACT_NONE,  79, 24},  // clamp both
        '{'{MODE_PUT, 8'hFF, 8'h00, 8'h00}, 1'b1, ACT_WRITE,  0, 24},  // wrap on last row
        '{'{MODE_SET, 8'h00, 8'd79, 8'd0},  1'b1, ACT_NONE,  79,  0},
        '{'{MODE_PUT, CH_TAB, 8'h00, 8'h00}, 1'b1, ACT_NONE,  0,  1},  // tab past last column
        '{'{MODE_SET, 8'h00, 8'd79, 8'd24}, 1'b1, ACT_NONE,  79, 24},
        '{'{MODE_PUT, CH_TAB, 8'h00, 8'h00}, 1'b1, ACT_SCROLL, 0, 24}, // tab wraps on last row
        '{'{MODE_PUT, CH_LF, 8'h00, 8'h00}, 1'b1, ACT_SCROLL,  0, 24}, // line feed on last row
        '{'{MODE_SET, 8'h00, 8'd78, 8'd10}, 1'b1, ACT_NONE,  78, 10},
        '{'{MODE_PUT, 8'h00, 8'h00, 8'h00}, 1'b1, ACT_WRITE, 79, 10},  // NUL is a cell
        '{'{MODE_PUT, 8'h7F, 8'h00, 8'h00}, 1'b1, ACT_WRITE,  0, 11},  // wrap, no scroll
        '{'{MODE_PUT, 8'h1B, 8'h00, 8'h00}, 1'b1, ACT_WRITE,  1, 11},  // other control byte
        '{'{MODE_SET, 8'h00, 8'd80, 8'd25}, 1'b1, ACT_NONE,  79, 24},  // just off screen
        '{'{MODE_SET, 8'hFF, 8'd0,  8'd0},  1'b1, ACT_NONE,   0,  0},
        '{'{MODE_PUT, 8'h55, 8'hAA, 8'h55}, 1'b0, ACT_NONE,   0,  0},
        '{'{MODE_PUT, 8'hAA, 8'h55, 8'hAA}, 1'b0, ACT_NONE,   0,  0},
        '{'{MODE_SET, 8'h00, 8'h80, 8'h7F}, 1'b1, ACT_NONE,  79, 24},
        '{'{MODE_PUT, 8'h0B, 8'h00, 8'h00}, 1'b1, ACT_WRITE,  0, 24}   // VT wraps on last row
    };

    logic i_clk;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tcc_in_if  in_if ();
    tcc_out_if out_if ();

    text_console_cursor_control dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Cursor mirror, attribute mirror and the results still owed by the block.
    logic [COL_W-1:0]  cur_col  = '0;
    logic [ROW_W-1:0]  cur_row  = '0;
    logic [BYTE_W-1:0] attr_now = ATTR_RESET;
    t_result           awaited_actions [$];

    int fail_count    = 0;
    int input_beats   = 0;
    int result_beats  = 0;
    int write_beats   = 0;
    int scroll_beats  = 0;
    int clear_beats   = 0;
    int wrap_scrolls  = 0;
    int attr_writes   = 0;
    int idle_cycles   = 0;
    int burst_left    = 0;

    initial i_clk = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h (result beat %0d)",
                                      name, got, want, result_beats));
    endtask

    // Build a result that carries the cursor as it stands after the whole input.
    function automatic t_result make_result(t_action act, logic [COL_W-1:0] c,
                                            logic [ROW_W-1:0] r, logic [BYTE_W-1:0] ch,
                                            logic [BYTE_W-1:0] at, logic last);
        t_result res;
        res.action         = act;
        res.cell_col       = c;
        res.cell_row       = r;
        res.cell_char      = ch;
        res.cell_attr      = at;
        res.cursor_col_now = cur_col;
        res.cursor_row_now = cur_row;
        res.last_result    = last;
        return res;
    endfunction

    // Drop to column 0 of the next row; return 1 when the screen must scroll instead.
    function automatic bit advance_line();
        cur_col = '0;
        if (int'(cur_row) + 1 >= ROWS) return 1'b1;
        cur_row = cur_row + 1'b1;
        return 1'b0;
    endfunction

    // Step the cursor mirror by one accepted beat and queue the results it owes.
    task automatic advance_cursor(input t_beat b, output t_result lead);
        int                n_before;
        int                tab_col;
        bit                wrap;
        logic [COL_W-1:0]  wc;
        logic [ROW_W-1:0]  wr;
        n_before = awaited_actions.size();
        wrap     = 1'b0;
        if (b.mode == MODE_SET) begin
            cur_col = (b.col < COLUMNS) ? COL_W'(b.col) : COL_W'(COLUMNS - 1);
            cur_row = (b.row < ROWS) ? ROW_W'(b.row) : ROW_W'(ROWS - 1);
            awaited_actions.push_back(make_result(ACT_NONE, '0, '0, '0, '0, 1'b1));
        end else begin
            case (b.ch)
                CH_BS: begin
                    if (cur_col != 0) cur_col = cur_col - 1'b1;
                end
                CH_TAB: begin
                    tab_col = (int'(cur_col) + TAB_STOP) & ~(TAB_STOP - 1);
                    if (tab_col >= COLUMNS) wrap = advance_line();
                    else cur_col = COL_W'(tab_col);
                end
                CH_LF: begin
                    wrap = advance_line();
                end
                CH_CR: begin
                    cur_col = '0;
                end
                CH_FF: begin
                    cur_col = '0;
                    cur_row = '0;
                end
                default: begin
                    wc = cur_col;
                    wr = cur_row;
                    if (int'(cur_col) + 1 >= COLUMNS) wrap = advance_line();
                    else cur_col = cur_col + 1'b1;
                end
            endcase
            if (b.ch == CH_FF) begin
                awaited_actions.push_back(make_result(ACT_CLEAR, '0, '0, FILL_CHAR, attr_now,
                                                      1'b1));
            end else if (!(b.ch inside {CH_BS, CH_TAB, CH_LF, CH_CR})) begin
                // cell first; a wrap on the last row adds the scroll behind it
                awaited_actions.push_back(make_result(ACT_WRITE, wc, wr, b.ch, attr_now, !wrap));
                if (wrap)
                    awaited_actions.push_back(make_result(ACT_SCROLL, '0, '0, FILL_CHAR,
                                                          attr_now, 1'b1));
            end else if (wrap) begin
                awaited_actions.push_back(make_result(ACT_SCROLL, '0, '0, FILL_CHAR, attr_now,
                                                      1'b1));
            end else begin
                awaited_actions.push_back(make_result(ACT_NONE, '0, '0, '0, '0, 1'b1));
            end
        end
        lead = awaited_actions[n_before];
    endtask

    // Beat monitor: score results, mirror inputs and register writes, and run the watchdog.
    // Everything is sampled at the rising edge, before the block's own updates land.
    always @(posedge i_clk) begin : beat_monitor
        t_result got;
        t_result want;
        t_result lead;
        t_beat   taken;
        bit      busy;
        if (i_rst_n) begin
            busy = 1'b0;

            // Score the result beat against the oldest owed result.
            if (out_if.valid && out_if.ready) begin
                busy = 1'b1;
                got.action         = t_action'(out_if.action);
                got.cell_col       = out_if.cell_col;
                got.cell_row       = out_if.cell_row;
                got.cell_char      = out_if.cell_char;
                got.cell_attr      = out_if.cell_attr;
                got.cursor_col_now = out_if.cursor_col_now;
                got.cursor_row_now = out_if.cursor_row_now;
                got.last_result    = out_if.last_result;
                if (awaited_actions.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing owed, action %0d",
                                              out_if.action));
                end else begin
                    want = awaited_actions.pop_front();
                    check_field("action",         got.action,         want.action);
                    check_field("cell_col",       got.cell_col,       want.cell_col);
                    check_field("cell_row",       got.cell_row,       want.cell_row);
                    check_field("cell_char",      got.cell_char,      want.cell_char);
                    check_field("cell_attr",      got.cell_attr,      want.cell_attr);
                    check_field("cursor_col_now", got.cursor_col_now, want.cursor_col_now);
                    check_field("cursor_row_now", got.cursor_row_now, want.cursor_row_now);
                    check_field("last_result",    got.last_result,    want.last_result);
                end
                case (got.action)
                    ACT_WRITE:  write_beats++;
                    ACT_SCROLL: scroll_beats++;
                    ACT_CLEAR:  clear_beats++;
                    default:    ;
                endcase
                if (got.action == ACT_WRITE && got.last_result === 1'b0) wrap_scrolls++;
                result_beats++;
            end

            // Predict the results of each accepted input beat.
            if (in_if.valid && in_if.ready) begin
                busy = 1'b1;
                taken.mode = in_if.mode;
                taken.ch   = in_if.char_code;
                taken.col  = in_if.col_request;
                taken.row  = in_if.row_request;
                advance_cursor(taken, lead);
                // Cross-check the hand-written rows against the prediction.
                if (input_beats < DIRECTED_N && directed_rows[input_beats].typed) begin
                    check_field("table action", lead.action, directed_rows[input_beats].act);
                    check_field("table col", lead.cursor_col_now,
                                directed_rows[input_beats].col_now);
                    check_field("table row", lead.cursor_row_now,
                                directed_rows[input_beats].row_now);
                end
                input_beats++;
            end

            // Track the attribute register as the bus writes it.
            if (psel && penable && pwrite && pready && paddr == ATTR_ADDR) begin
                attr_now = pwdata[BYTE_W-1:0];
                attr_writes++;
            end
            if (psel) busy = 1'b1;

            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no beat moved for %0d cycles, %0d results owed",
                         $time, idle_cycles, awaited_actions.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver: alternate stretches of steady ready with stretches of light and
    // heavy stalling, so backpressure lands on every phase of the block.
    initial begin : result_sink
        int ready_pct;
        int stretch;
        out_if.ready <= 1'b0;
        ready_pct = 100;
        stretch   = 0;
        forever begin
            @(posedge i_clk);
            if (stretch == 0) begin
                case ($urandom_range(3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 75;
                    2:       ready_pct = 40;
                    default: ready_pct = 15;
                endcase
                stretch = $urandom_range(200, 20);
            end
            stretch--;
            out_if.ready <= ($urandom_range(99) < ready_pct);
        end
    end

    // Present one beat and hold it until the block takes it. Leave valid high.
    task automatic send_beat(input t_beat b);
        in_if.valid       <= 1'b1;
        in_if.mode        <= b.mode;
        in_if.char_code   <= b.ch;
        in_if.col_request <= b.col;
        in_if.row_request <= b.row;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Burst pacing: advance within the burst, or drop valid for a random gap
    // and start a new burst. Zero gaps chain bursts into idle-free stretches.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            case ($urandom_range(7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(24, 7);
                default: gap = $urandom_range(6, 1);
            endcase
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(120, 40)
                                                  : $urandom_range(16, 1);
        end
    endtask

    // Drop valid and hold until every owed result has arrived.
    task automatic hold_until_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_actions.size() != 0);
    endtask

    task automatic write_attribute(input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ATTR_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_attribute_check();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ATTR_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("attribute readback", prdata[BYTE_W-1:0], attr_now);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pick a position request: anywhere in the byte, hugging the screen edge, or on screen.
    function automatic logic [BYTE_W-1:0] pick_request(int span);
        case ($urandom_range(2))
            0:       return BYTE_W'($urandom_range(255));
            1:       return BYTE_W'($urandom_range(span + 1, span - 2));
            default: return BYTE_W'($urandom_range(span - 1));
        endcase
    endfunction

    // Random beat: mostly cells, a fair share of cursor controls, some clears
    // and set-position requests aimed at the right and bottom edges so that
    // wraps and last-row scrolls come often. Ignored fields stay random.
    function automatic t_beat random_beat();
        t_beat b;
        int    pick;
        b.mode = MODE_PUT;
        b.ch   = BYTE_W'($urandom_range(255));
        b.col  = BYTE_W'($urandom_range(255));
        b.row  = BYTE_W'($urandom_range(255));
        pick   = $urandom_range(99);
        if (pick < 10)      b.ch = CH_BS;
        else if (pick < 19) b.ch = CH_TAB;
        else if (pick < 26) b.ch = CH_LF;
        else if (pick < 32) b.ch = CH_CR;
        else if (pick < 34) b.ch = CH_FF;
        else if (pick < 47) begin
            b.mode = MODE_SET;
            b.col  = pick_request(COLUMNS);
            b.row  = pick_request(ROWS);
        end
        return b;
    endfunction

    initial begin : stimulus
        logic [BYTE_W-1:0] attr_val;
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.mode        <= MODE_PUT;
        in_if.char_code   <= '0;
        in_if.col_request <= '0;
        in_if.row_request <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset value of the attribute, then the directed sequence under it.
        read_attribute_check();
        for (int i = 0; i < DIRECTED_N; i++) begin
            send_beat(directed_rows[i].beat);
            pace_sender();
        end

        // One phase per attribute setting, extremes first. Drain before each
        // register write so the block is idle when it lands.
        for (int phase = 0; phase < PHASES; phase++) begin
            hold_until_drained();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            case (phase)
                0:       attr_val = 8'h00;
                1:       attr_val = 8'hFF;
                2:       attr_val = 8'hA5;
                3:       attr_val = 8'h5A;
                default: attr_val = BYTE_W'($urandom_range(255));
            endcase
            // Upper bus bits are noise; only the low byte is the register.
            write_attribute({24'($urandom), attr_val});
            read_attribute_check();
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_beat(random_beat());
                pace_sender();
                if ($urandom_range(149) == 0) hold_until_drained();
            end
        end

        // Let the pipeline empty, then idle long enough to catch stray beats.
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input beats, %0d result beats: %0d cells, %0d scrolls",
                 input_beats, result_beats, write_beats, scroll_beats);
        $display("  (%0d scrolls after a last-row wrap), %0d clears, %0d attribute writes",
                 wrap_scrolls, clear_beats, attr_writes);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
